@@ rtl/lobm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and constants shared by the order book matcher modules.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int DEF_BOOK_DEPTH = 32;
    localparam int DEF_NUM_BOOKS  = 4;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_TRADE  = 2'd1,
        KIND_DROP   = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MREAD,
        S_MWAIT,
        S_REST,
        S_IREAD,
        S_IWAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  instrument;
        logic        side;
        logic [31:0] price;
        logic [30:0] quantity;
    } order_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] new_order_id;
        logic [31:0] resting_order_id;
        logic [30:0] fill_qty;
        logic [31:0] trade_price;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [31:0] price;
        logic [30:0] quantity;
        logic [31:0] id;
    } entry_t;

endpackage
`default_nettype wire

@@ rtl/lobm_book_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_book_ram
// Entry storage for all book sides, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lobm_book_ram
    import lobm_pkg::*;
#(
    parameter int DEPTH  = 2 * DEF_NUM_BOOKS * DEF_BOOK_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/limit_order_book_matcher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority matcher: per book a bid and an ask side in one RAM,
// each side a circular list, best first. Orders match, then a remainder rests or drops.
// ----------------------------------------------------------------------------
// A reject is registered and leaves in the cycle after the order. Other results
// wait in a pending register; the accept leaves at the first trade or drop found,
// or as the last result. An order is loaded, each trade reads the best opposite
// entry, its side is checked, entries shift, it is inserted, the last result sent;
// output stalls hold the steps. One order is in work at a time, taken in S_IDLE.
// Reset clears all counts and heads and sets the next id to 1; RAM is not cleared.
// ----------------------------------------------------------------------------
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = DEF_BOOK_DEPTH,
    parameter int NUM_BOOKS  = DEF_NUM_BOOKS
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire order_t  order,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      result
);

    localparam int NTAB    = 2 * NUM_BOOKS;
    localparam int TAB_W   = $clog2(NTAB);
    localparam int SLOT_W  = $clog2(BOOK_DEPTH);
    localparam int CNT_W   = $clog2(BOOK_DEPTH + 1);
    localparam int PW      = CNT_W + 1;
    localparam int RAM_D   = NTAB * BOOK_DEPTH;
    localparam int ADDR_W  = $clog2(RAM_D);

    state_t              state_reg, state_next;
    logic [1:0]          instr_reg, instr_next;
    logic                side_reg, side_next;
    logic [31:0]         price_reg, price_next;
    logic [30:0]         rem_reg, rem_next;
    logic [31:0]         id_reg, id_next;
    logic [31:0]         next_id_reg, next_id_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    result_t             pend_reg, pend_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]    cnt_reg [NTAB];
    logic [SLOT_W-1:0]   head_reg [NTAB];

    logic                cnt_we, head_we;
    logic [TAB_W-1:0]    cnt_idx, head_idx;
    logic [CNT_W-1:0]    cnt_val;
    logic [SLOT_W-1:0]   head_val;

    logic                wr_en, rd_en;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    entry_t              wr_data, rd_data;

    logic                out_free;
    logic [TAB_W-1:0]    opp_tab, own_tab;
    logic [CNT_W-1:0]    lidx;
    logic [PW-1:0]       psum;
    logic [SLOT_W-1:0]   own_phys, opp_head;
    logic [ADDR_W-1:0]   own_addr, opp_addr;
    logic                crosses, stop;
    logic [30:0]         fill_q;
    logic [30:0]         left_q;
    logic                bad;
    logic [SLOT_W:0]     hsum;

    lobm_book_ram #(
        .DEPTH  (RAM_D),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    assign own_tab = TAB_W'(32'(instr_reg) * 2 + 32'(side_reg));
    assign opp_tab = TAB_W'(32'(instr_reg) * 2 + 32'(!side_reg));
    assign bad     = (order.price == 32'd0) || (order.quantity == 31'd0)
                   || (32'(order.instrument) >= NUM_BOOKS);

    assign lidx = ((state_reg == S_IREAD) && (idx_reg != '0)) ? idx_reg - 1'b1 : idx_reg;
    assign psum = PW'(head_reg[own_tab]) + PW'(lidx);
    assign own_phys = (psum >= PW'(BOOK_DEPTH)) ? SLOT_W'(psum - PW'(BOOK_DEPTH))
                                                : SLOT_W'(psum);
    assign opp_head = head_reg[opp_tab];
    assign own_addr = ADDR_W'(32'(own_tab) * BOOK_DEPTH + 32'(own_phys));
    assign opp_addr = ADDR_W'(32'(opp_tab) * BOOK_DEPTH + 32'(opp_head));
    assign hsum = (SLOT_W + 1)'(opp_head) + 1'b1;

    assign crosses = side_reg ? (price_reg <= rd_data.price) : (price_reg >= rd_data.price);
    assign stop    = side_reg ? (rd_data.price <= price_reg) : (rd_data.price >= price_reg);
    assign fill_q  = (rem_reg < rd_data.quantity) ? rem_reg : rd_data.quantity;
    assign left_q  = rd_data.quantity - fill_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            next_id_reg   <= 32'd1;
            for (int t = 0; t < NTAB; t++)
            begin
                cnt_reg[t]  <= '0;
                head_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            next_id_reg   <= next_id_next;
            if (cnt_we)
            begin
                cnt_reg[cnt_idx] <= cnt_val;
            end
            if (head_we)
            begin
                head_reg[head_idx] <= head_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg <= instr_next;
        side_reg  <= side_next;
        price_reg <= price_next;
        rem_reg   <= rem_next;
        id_reg    <= id_next;
        idx_reg   <= idx_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        instr_next     = instr_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        rem_next       = rem_reg;
        id_next        = id_reg;
        next_id_next   = next_id_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cnt_we   = 1'b0;
        cnt_idx  = own_tab;
        cnt_val  = cnt_reg[own_tab];
        head_we  = 1'b0;
        head_idx = opp_tab;
        head_val = opp_head;
        wr_en    = 1'b0;
        wr_addr  = own_addr;
        wr_data  = rd_data;
        rd_en    = 1'b0;
        rd_addr  = own_addr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    if (bad)
                    begin
                        out_next       = '0;
                        out_next.kind  = KIND_REJECT;
                        out_next.last  = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        instr_next   = order.instrument;
                        side_next    = order.side;
                        price_next   = order.price;
                        rem_next     = order.quantity;
                        id_next      = next_id_reg;
                        next_id_next = next_id_reg + 32'd1;
                        pend_next    = '0;
                        pend_next.kind = KIND_ACCEPT;
                        pend_next.new_order_id = next_id_reg;
                        state_next   = S_MREAD;
                    end
                end
            end
            S_MREAD:
            begin
                if (cnt_reg[opp_tab] == '0)
                begin
                    state_next = S_REST;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = opp_addr;
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                if (!crosses)
                begin
                    state_next = S_REST;
                end
                else if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    pend_next      = '0;
                    pend_next.kind = KIND_TRADE;
                    pend_next.new_order_id     = id_reg;
                    pend_next.resting_order_id = rd_data.id;
                    pend_next.fill_qty         = fill_q;
                    pend_next.trade_price      = rd_data.price;
                    rem_next = rem_reg - fill_q;
                    if (left_q == 31'd0)
                    begin
                        head_we  = 1'b1;
                        head_val = (hsum >= (SLOT_W + 1)'(BOOK_DEPTH)) ? '0 : SLOT_W'(hsum);
                        cnt_we   = 1'b1;
                        cnt_idx  = opp_tab;
                        cnt_val  = cnt_reg[opp_tab] - 1'b1;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = opp_addr;
                        wr_data = '{price: rd_data.price, quantity: left_q, id: rd_data.id};
                    end
                    state_next = (rem_reg == fill_q) ? S_DONE : S_MREAD;
                end
            end
            S_REST:
            begin
                if (cnt_reg[own_tab] >= CNT_W'(BOOK_DEPTH))
                begin
                    if (out_free)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                        pend_next      = '0;
                        pend_next.kind = KIND_DROP;
                        pend_next.new_order_id = id_reg;
                        pend_next.fill_qty     = rem_reg;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    idx_next   = cnt_reg[own_tab];
                    state_next = S_IREAD;
                end
            end
            S_IREAD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_data    = '{price: price_reg, quantity: rem_reg, id: id_reg};
                    cnt_we     = 1'b1;
                    cnt_val    = cnt_reg[own_tab] + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_IWAIT;
                end
            end
            S_IWAIT:
            begin
                wr_en = 1'b1;
                if (stop)
                begin
                    wr_data    = '{price: price_reg, quantity: rem_reg, id: id_reg};
                    cnt_we     = 1'b1;
                    cnt_val    = cnt_reg[own_tab] + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_IREAD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
